FILE: hdl/lcdnib_pkg.sv
// Shared types, codes and init command table for the LCD nibble write sequencer.
package lcdnib_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_POWER  = 3'd1,
    PH_HI     = 3'd2,
    PH_GAP    = 3'd3,
    PH_LO     = 3'd4,
    PH_SETTLE = 3'd5,
    PH_EXTRA  = 3'd6
  } phase_t;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_COMMAND = 3'd1;
  localparam logic [2:0] OP_DATA    = 3'd2;
  localparam logic [2:0] OP_CURSOR  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_INIT    = 3'd5;

  localparam logic [1:0] REG_PULSE    = 2'd0;
  localparam logic [1:0] REG_GAP      = 2'd1;
  localparam logic [1:0] REG_SETTLE   = 2'd2;
  localparam logic [1:0] REG_POWER_ON = 2'd3;

  localparam logic [7:0]  PULSE_RESET    = 8'd1;
  localparam logic [9:0]  GAP_RESET      = 10'd200;
  localparam logic [12:0] SETTLE_RESET   = 13'd2000;
  localparam logic [15:0] POWER_ON_RESET = 16'd20000;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;

  localparam logic [2:0] INIT_LAST = 3'd4;

  function automatic logic [7:0] init_cmd(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h02;
      3'd1:    c = 8'h28;
      3'd2:    c = 8'h0C;
      3'd3:    c = 8'h06;
      3'd4:    c = 8'h01;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/char_lcd_nibble_write_sequencer.sv
// Top level: 4-bit character LCD write sequencer with tick-driven timing.
//
// Input channel (in_valid/in_stall) carries one item per request: op selects a
// microsecond tick, a command byte, a data byte, a cursor move, clear or init.
// Each accepted item steps the sequencer once and yields exactly one result on
// the output channel (out_valid/out_stall): the pin levels data_nibble,
// reg_select and enable after the item, busy_res, and rejected for a request
// that arrived while a transfer or wait was running (it is dropped).
// The result is registered; one item per cycle is taken while in_stall is low.
// A two-entry output stage (result register plus skid register) lets an item be
// taken while the previous result still waits; in_stall rises only once both
// entries are full, i.e. after the receiver stalls two results. Timing
// registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, as the block does not enforce it. Times wider than
// TIMER_BITS saturate and zero acts as one tick. Reset (rst, synchronous)
// returns the sequencer to idle with all held values zero, restores the default
// timings and empties the output stage.
module char_lcd_nibble_write_sequencer #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  value,
  input  logic [5:0]  column,
  input  logic [1:0]  row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  data_nibble,
  output logic        reg_select,
  output logic        enable,
  output logic        busy_res,
  output logic        rejected
);
  import lcdnib_pkg::*;

  localparam int LW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       reg_select;
    logic       enable;
    logic       busy_res;
    logic       rejected;
  } result_t;

  logic [7:0]  pulse_us;
  logic [9:0]  gap_us;
  logic [12:0] settle_us;
  logic [15:0] power_on_us;

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] countdown, countdown_next;
  logic [7:0]            byte_held, byte_held_next;
  logic                  select_held, select_held_next;
  logic [2:0]            init_index, init_index_next;
  logic                  extra_settle, extra_settle_next;
  logic [3:0]            nibble_out, nibble_out_next;

  logic [TIMER_BITS-1:0] pulse_ld, gap_ld, settle_ld, power_ld;
  logic                  accept, busy, rej;
  logic                  start, start_sel;
  logic [7:0]            start_byte;
  result_t               result, out_res, skid_res;
  logic                  skid_valid;

  function automatic logic [TIMER_BITS-1:0] tload(input logic [15:0] t);
    logic [LW-1:0] tw;
    logic [LW-1:0] maxv;
    tw   = LW'(t);
    maxv = LW'({TIMER_BITS{1'b1}});
    return (tw > maxv) ? {TIMER_BITS{1'b1}} : tw[TIMER_BITS-1:0];
  endfunction

  assign pulse_ld  = tload({8'd0, pulse_us});
  assign gap_ld    = tload({6'd0, gap_us});
  assign settle_ld = tload({3'd0, settle_us});
  assign power_ld  = tload(power_on_us);

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_us    <= PULSE_RESET;
      gap_us      <= GAP_RESET;
      settle_us   <= SETTLE_RESET;
      power_on_us <= POWER_ON_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE:    pulse_us    <= cfg_data[7:0];
        REG_GAP:      gap_us      <= cfg_data[9:0];
        REG_SETTLE:   settle_us   <= cfg_data[12:0];
        REG_POWER_ON: power_on_us <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;
  assign busy   = (phase != PH_IDLE);

  always_comb begin
    phase_next        = phase;
    countdown_next    = countdown;
    byte_held_next    = byte_held;
    select_held_next  = select_held;
    init_index_next   = init_index;
    extra_settle_next = extra_settle;
    nibble_out_next   = nibble_out;
    rej               = 1'b0;
    start             = 1'b0;
    start_sel         = 1'b0;
    start_byte        = 8'd0;

    if (op == OP_TICK) begin
      if (busy) begin
        if (countdown > TIMER_BITS'(1)) begin
          countdown_next = countdown - TIMER_BITS'(1);
        end else begin
          case (phase)
            PH_POWER: begin
              init_index_next = 3'd1;
              start           = 1'b1;
              start_byte      = init_cmd(3'd0);
            end
            PH_HI: begin
              phase_next     = PH_GAP;
              countdown_next = gap_ld;
            end
            PH_GAP: begin
              nibble_out_next = byte_held[3:0];
              phase_next      = PH_LO;
              countdown_next  = pulse_ld;
            end
            PH_LO: begin
              phase_next     = PH_SETTLE;
              countdown_next = settle_ld;
            end
            PH_SETTLE: begin
              if (init_index inside {[3'd1:INIT_LAST]}) begin
                init_index_next = init_index + 3'd1;
                start           = 1'b1;
                start_byte      = init_cmd(init_index);
              end else begin
                init_index_next = 3'd0;
                if (extra_settle) begin
                  extra_settle_next = 1'b0;
                  phase_next        = PH_EXTRA;
                  countdown_next    = settle_ld;
                end else begin
                  phase_next     = PH_IDLE;
                  countdown_next = '0;
                end
              end
            end
            default: begin
              phase_next     = PH_IDLE;
              countdown_next = '0;
            end
          endcase
        end
      end
    end else if (op <= OP_INIT) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        case (op)
          OP_COMMAND: begin
            start      = 1'b1;
            start_byte = value;
          end
          OP_DATA: begin
            start      = 1'b1;
            start_sel  = 1'b1;
            start_byte = value;
          end
          OP_CURSOR: begin
            if (row == 2'd1) begin
              start      = 1'b1;
              start_byte = ROW1_BASE + {2'd0, column};
            end else if (row == 2'd2) begin
              start      = 1'b1;
              start_byte = ROW2_BASE + {2'd0, column};
            end
          end
          OP_CLEAR: begin
            extra_settle_next = 1'b1;
            start             = 1'b1;
            start_byte        = CMD_CLEAR;
          end
          default: begin
            extra_settle_next = 1'b1;
            init_index_next   = 3'd0;
            phase_next        = PH_POWER;
            countdown_next    = power_ld;
          end
        endcase
      end
    end

    if (start) begin
      byte_held_next   = start_byte;
      select_held_next = start_sel;
      nibble_out_next  = start_byte[7:4];
      phase_next       = PH_HI;
      countdown_next   = pulse_ld;
    end

    result.data_nibble = nibble_out_next;
    result.reg_select  = select_held_next;
    result.enable      = (phase_next == PH_HI) || (phase_next == PH_LO);
    result.busy_res    = (phase_next != PH_IDLE);
    result.rejected    = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      countdown    <= '0;
      byte_held    <= 8'd0;
      select_held  <= 1'b0;
      init_index   <= 3'd0;
      extra_settle <= 1'b0;
      nibble_out   <= 4'd0;
    end else if (accept) begin
      phase        <= phase_next;
      countdown    <= countdown_next;
      byte_held    <= byte_held_next;
      select_held  <= select_held_next;
      init_index   <= init_index_next;
      extra_settle <= extra_settle_next;
      nibble_out   <= nibble_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_res <= skid_valid ? skid_res : result;
    end else if (accept) begin
      skid_res <= result;
    end
  end

  assign in_stall    = skid_valid;
  assign data_nibble = out_res.data_nibble;
  assign reg_select  = out_res.reg_select;
  assign enable      = out_res.enable;
  assign busy_res    = out_res.busy_res;
  assign rejected    = out_res.rejected;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && enable) |-> busy_res)
    else $error("enable reported without busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && result.rejected) |-> (busy && result.busy_res))
    else $error("request rejected while idle");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (countdown == '0 && init_index == 3'd0))
    else $error("idle with timer or init sequence pending");

endmodule

FILE: bench/char_lcd_nibble_write_sequencer_tb.sv
// Self-checking bench for the LCD nibble write sequencer: directed rows, then random timed phases.
module char_lcd_nibble_write_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdnib_pkg::*;

  localparam int TIMER_BITS = 16;
  localparam logic [31:0] TIMER_MAX = (32'd1 << TIMER_BITS) - 32'd1;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [1:0] ROW_FIRST = 2'd1;
  localparam logic [1:0] ROW_SECOND = 2'd2;
  localparam logic SEL_CMD = 1'b0;
  localparam logic SEL_DATA = 1'b1;
  // power-up command sequence, first command in the low byte
  localparam logic [39:0] INIT_SEQ = {8'h01, 8'h06, 8'h0C, 8'h28, 8'h02};
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 90;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       en;
    logic       busy;
    logic       rej;
  } pins_t;

  typedef struct {
    logic [2:0] d_op;
    logic [7:0] d_value;
    logic [5:0] d_column;
    logic [1:0] d_row;
    logic       has_want;
    pins_t      want;
    logic       run_out;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  op;
  logic [7:0]  value;
  logic [5:0]  column;
  logic [1:0]  row;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  data_nibble;
  logic        reg_select;
  logic        enable;
  logic        busy_res;
  logic        rejected;

  char_lcd_nibble_write_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .value(value), .column(column), .row(row),
    .out_valid(out_valid), .out_stall(out_stall),
    .data_nibble(data_nibble), .reg_select(reg_select), .enable(enable),
    .busy_res(busy_res), .rejected(rejected)
  );

  // sequencer mirror
  phase_t                seq_phase;
  logic [TIMER_BITS-1:0] seq_count;
  logic [7:0]            seq_byte;
  logic                  seq_rs;
  logic [2:0]            seq_init;
  logic                  seq_extra;
  logic [3:0]            seq_nib;
  logic [7:0]            t_pulse;
  logic [9:0]            t_gap;
  logic [12:0]           t_settle;
  logic [15:0]           t_power;

  pins_t    pending_pins[$];
  dir_row_t dir_rows[$];
  int       mismatches;
  logic     quiet;
  logic     no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [TIMER_BITS-1:0] clamp_time(input logic [31:0] t);
    return (t > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0] : t[TIMER_BITS-1:0];
  endfunction

  function automatic void load_byte(input logic [7:0] b, input logic sel);
    seq_byte = b;
    seq_rs = sel;
    seq_nib = b[7:4];
    seq_phase = PH_HI;
    seq_count = clamp_time(32'(t_pulse));
  endfunction

  function automatic void next_phase();
    logic [2:0] k;
    case (seq_phase)
      PH_POWER: begin
        seq_init = 3'd1;
        load_byte(INIT_SEQ[7:0], SEL_CMD);
      end
      PH_HI: begin
        seq_phase = PH_GAP;
        seq_count = clamp_time(32'(t_gap));
      end
      PH_GAP: begin
        seq_nib = seq_byte[3:0];
        seq_phase = PH_LO;
        seq_count = clamp_time(32'(t_pulse));
      end
      PH_LO: begin
        seq_phase = PH_SETTLE;
        seq_count = clamp_time(32'(t_settle));
      end
      PH_SETTLE: begin
        if (seq_init >= 3'd1 && seq_init <= INIT_LAST) begin
          k = seq_init;
          seq_init = k + 3'd1;
          load_byte(INIT_SEQ[8*k +: 8], SEL_CMD);
        end else begin
          seq_init = 3'd0;
          if (seq_extra) begin
            seq_extra = 1'b0;
            seq_phase = PH_EXTRA;
            seq_count = clamp_time(32'(t_settle));
          end else begin
            seq_phase = PH_IDLE;
            seq_count = '0;
          end
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        seq_count = '0;
      end
    endcase
  endfunction

  function automatic pins_t pins_after(input logic [2:0] o, input logic [7:0] v,
                                       input logic [5:0] c, input logic [1:0] r);
    pins_t p;
    logic  busy;
    p.rej = 1'b0;
    busy = (seq_phase != PH_IDLE);
    if (o == OP_TICK) begin
      if (busy) begin
        if (seq_count > 1) seq_count = seq_count - 1'b1;
        else next_phase();
      end
    end else if (o <= OP_INIT) begin
      if (busy) begin
        p.rej = 1'b1;
      end else begin
        case (o)
          OP_COMMAND: load_byte(v, SEL_CMD);
          OP_DATA: load_byte(v, SEL_DATA);
          OP_CURSOR: begin
            if (r == ROW_FIRST) load_byte(ROW1_BASE + 8'(c), SEL_CMD);
            else if (r == ROW_SECOND) load_byte(ROW2_BASE + 8'(c), SEL_CMD);
          end
          OP_CLEAR: begin
            seq_extra = 1'b1;
            load_byte(CMD_CLEAR, SEL_CMD);
          end
          default: begin
            seq_extra = 1'b1;
            seq_init = 3'd0;
            seq_phase = PH_POWER;
            seq_count = clamp_time(32'(t_power));
          end
        endcase
      end
    end
    p.nibble = seq_nib;
    p.rs = seq_rs;
    p.en = (seq_phase == PH_HI || seq_phase == PH_LO);
    p.busy = (seq_phase != PH_IDLE);
    return p;
  endfunction

  function automatic void flag(input string name, input logic [3:0] want, input logic [3:0] got);
    mismatches++;
    $error("%s: expected %0h, got %0h", name, want, got);
  endfunction

  task automatic check_pins();
    pins_t want;
    if (pending_pins.size() == 0) begin
      mismatches++;
      $error("result with no request pending");
    end else begin
      want = pending_pins.pop_front();
      if (data_nibble !== want.nibble) flag("data_nibble", want.nibble, data_nibble);
      if (reg_select !== want.rs) flag("reg_select", 4'(want.rs), 4'(reg_select));
      if (enable !== want.en) flag("enable", 4'(want.en), 4'(enable));
      if (busy_res !== want.busy) flag("busy_res", 4'(want.busy), 4'(busy_res));
      if (rejected !== want.rej) flag("rejected", 4'(want.rej), 4'(rejected));
    end
  endtask

  // receiver: random stall after each result
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        check_pins();
        hold = (quiet || no_idle) ? 0 : $urandom_range(0, 4);
      end else if (hold != 0) begin
        hold--;
      end
      out_stall <= (hold != 0);
    end
  end

  // called at a clock edge; the caller follows on in zero time
  task automatic send_item(input logic [2:0] o, input logic [7:0] v, input logic [5:0] c,
                           input logic [1:0] r, input logic has_want, input pins_t want);
    int    gap;
    pins_t pred;
    gap = (quiet || no_idle) ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    column <= c;
    row <= r;
    do @(posedge clk); while (in_stall);
    pred = pins_after(o, v, c, r);
    pending_pins.push_back(has_want ? want : pred);
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
  endtask

  task automatic run_out();
    quiet = 1'b1;
    while (seq_phase != PH_IDLE)
      send_item(OP_TICK, 8'($urandom), 6'($urandom), 2'($urandom), 1'b0, '0);
    quiet = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      REG_PULSE: t_pulse = d[7:0];
      REG_GAP: t_gap = d[9:0];
      REG_SETTLE: t_settle = d[12:0];
      default: t_power = d;
    endcase
  endtask

  task automatic set_timing(input logic [15:0] p, input logic [15:0] g,
                            input logic [15:0] s, input logic [15:0] w);
    await_results();
    write_reg(REG_PULSE, p);
    write_reg(REG_GAP, g);
    write_reg(REG_SETTLE, s);
    write_reg(REG_POWER_ON, w);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input logic [2:0] o, input logic [7:0] v, input logic [5:0] c,
                         input logic [1:0] r, input logic has_want, input pins_t want,
                         input logic finish_it);
    dir_row_t d;
    d.d_op = o;
    d.d_value = v;
    d.d_column = c;
    d.d_row = r;
    d.has_want = has_want;
    d.want = want;
    d.run_out = finish_it;
    dir_rows.push_back(d);
  endtask

  task automatic random_item();
    int         pick;
    logic [2:0] o;
    pick = $urandom_range(0, 99);
    if (pick < 55) o = OP_TICK;
    else if (pick < 58) o = OP_SPARE_6;
    else if (pick < 60) o = OP_SPARE_7;
    else o = 3'($urandom_range(OP_COMMAND, OP_INIT));
    send_item(o, 8'($urandom), 6'($urandom), 2'($urandom), 1'b0, '0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_TICK;
    value = '0;
    column = '0;
    row = '0;
    out_stall = 1'b0;
    quiet = 1'b0;
    no_idle = 1'b0;
    mismatches = 0;
    t_pulse = PULSE_RESET;
    t_gap = GAP_RESET;
    t_settle = SETTLE_RESET;
    t_power = POWER_ON_RESET;
    seq_phase = PH_IDLE;
    seq_count = '0;
    seq_byte = '0;
    seq_rs = 1'b0;
    seq_init = '0;
    seq_extra = 1'b0;
    seq_nib = '0;

    // default timings; pins are {nibble, rs, en, busy, rejected}
    add_row(OP_TICK, 8'h00, 6'd0, 2'd0, 1'b1, {4'h0, 4'b0000}, 1'b0);
    add_row(OP_SPARE_6, 8'hFF, 6'd63, 2'd3, 1'b1, {4'h0, 4'b0000}, 1'b0);
    add_row(OP_SPARE_7, 8'h00, 6'd0, 2'd1, 1'b1, {4'h0, 4'b0000}, 1'b0);
    add_row(OP_CURSOR, 8'h00, 6'd5, 2'd0, 1'b1, {4'h0, 4'b0000}, 1'b0);
    add_row(OP_CURSOR, 8'hFF, 6'd63, 2'd3, 1'b1, {4'h0, 4'b0000}, 1'b0);
    add_row(OP_COMMAND, 8'hFF, 6'd0, 2'd0, 1'b1, {4'hF, 4'b0110}, 1'b0);
    // requests while busy are dropped
    add_row(OP_DATA, 8'h00, 6'd0, 2'd0, 1'b1, {4'hF, 4'b0111}, 1'b0);
    add_row(OP_CURSOR, 8'h00, 6'd0, 2'd3, 1'b1, {4'hF, 4'b0111}, 1'b0);
    add_row(OP_CLEAR, 8'h00, 6'd0, 2'd0, 1'b1, {4'hF, 4'b0111}, 1'b0);
    add_row(OP_INIT, 8'h00, 6'd0, 2'd0, 1'b1, {4'hF, 4'b0111}, 1'b0);
    add_row(OP_SPARE_7, 8'h00, 6'd0, 2'd0, 1'b1, {4'hF, 4'b0110}, 1'b0);
    add_row(OP_TICK, 8'h00, 6'd0, 2'd0, 1'b1, {4'hF, 4'b0010}, 1'b1);
    add_row(OP_DATA, 8'h00, 6'd0, 2'd0, 1'b1, {4'h0, 4'b1110}, 1'b1);
    add_row(OP_CURSOR, 8'h00, 6'd39, 2'd1, 1'b1, {4'hA, 4'b0110}, 1'b1);
    // last column on the second row: 0xC0 + 0x3F gives 0xFF, with no wrap
    add_row(OP_CURSOR, 8'h00, 6'd63, 2'd2, 1'b1, {4'hF, 4'b0110}, 1'b1);
    add_row(OP_CLEAR, 8'h00, 6'd0, 2'd0, 1'b1, {4'h0, 4'b0110}, 1'b1);
    add_row(OP_INIT, 8'h00, 6'd0, 2'd0, 1'b1, {4'h1, 4'b0010}, 1'b1);
    add_row(OP_TICK, 8'h00, 6'd0, 2'd0, 1'b1, {4'h1, 4'b0000}, 1'b0);
    add_row(OP_COMMAND, 8'hA5, 6'd0, 2'd0, 1'b0, '0, 1'b0);
    add_row(OP_DATA, 8'h5A, 6'd0, 2'd0, 1'b0, '0, 1'b1);
    add_row(OP_DATA, 8'h5A, 6'd0, 2'd0, 1'b0, '0, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].d_op, dir_rows[i].d_value, dir_rows[i].d_column,
                dir_rows[i].d_row, dir_rows[i].has_want, dir_rows[i].want);
      if (dir_rows[i].run_out) run_out();
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        // zero in every register, high data bits masked off
        0: set_timing(16'hFF00, 16'hFC00, 16'hE000, 16'h0000);
        1: set_timing(16'd1, 16'd1, 16'd1, 16'd1);
        RANDOM_PHASES - 1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
                            16'($urandom_range(0, 10)), 16'($urandom_range(0, 12)));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      if (ph == RANDOM_PHASES - 1) begin
        // longest timings: one full power-up, 20 random items on top
        send_item(OP_INIT, 8'($urandom), 6'($urandom), 2'($urandom), 1'b0, '0);
        repeat (20) random_item();
      end else begin
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
          random_item();
          if ($urandom_range(0, 39) == 0) await_results();
        end
      end
      run_out();
      no_idle = 1'b0;
    end

    await_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_pins.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
